/* sv/sle_pkg.sv */
// Shared types, codes and sizes of the serial line editor.
// Used by the top level, the sequencer, the result queue and the bench; depends on nothing.
`default_nettype none

package sle_pkg;

   localparam int BUF_DEPTH   = 256;
   localparam int PTR_W       = $clog2(BUF_DEPTH);
   localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
   localparam int MAX_RESULTS = 3;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = 2;
   localparam int OUT_CNT_W   = 3;

   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SP       = 8'h20;
   localparam logic [7:0] CH_DEL      = 8'h7F;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;

   typedef enum logic [1:0] {
      ACT_RX   = 2'd0,
      ACT_READ = 2'd1,
      ACT_PUT  = 2'd2,
      ACT_DONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_READ          = 2'd0,
      KIND_TX            = 2'd1,
      KIND_REFUSED       = 2'd2,
      KIND_SECOND_READER = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_FETCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic        last;
   } res_type;

   typedef struct packed {
      logic [1:0]                    count;
      res_type [MAX_RESULTS-1:0]     item;
   } out_push_type;

endpackage

`default_nettype wire

/* sv/serial_line_editor_with_echo.sv */
// Top level of the serial line editor: sequencer, two stores and the result queue.
// Depends on sle_pkg, sle_ram, sle_out_fifo and sle_ctrl.
//
// An input beat is taken in the idle step; each echo or put byte it hands to the send
// queue (none to three, counted whether the byte is kept or dropped on a full queue)
// then gets a push step of its own, as the send store has a single write port, and
// the fetch and emit steps follow. The next beat is taken into a holding register
// while the current one is still at work. Results wait in a four-entry queue, and a
// beat finishes only when that queue has room for three more results, so a stalled
// result side holds back input once two results are waiting.
// Each beat gives zero to three result beats, the final one marked by rsp_last.
// Both stores start undefined and are filled as lines and echoes arrive.
`default_nettype none

module serial_line_editor_with_echo (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_data_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [1:0] rsp_kind,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_last
);

   logic                        line_we, send_we, out_ready;
   logic [sle_pkg::PTR_W-1:0]   line_wa, line_ra, send_wa, send_ra;
   logic [7:0]                  line_wd, line_rd, send_wd, send_rd;
   sle_pkg::out_push_type       out_push;

   sle_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .line_we       (line_we),
      .line_wa       (line_wa),
      .line_wd       (line_wd),
      .line_ra       (line_ra),
      .line_rd       (line_rd),
      .send_we       (send_we),
      .send_wa       (send_wa),
      .send_wd       (send_wd),
      .send_ra       (send_ra),
      .send_rd       (send_rd),
      .out_ready     (out_ready),
      .out_push      (out_push)
   );

   sle_ram #(
      .WIDTH (8),
      .DEPTH (sle_pkg::BUF_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_wa),
      .wr_data (line_wd),
      .rd_addr (line_ra),
      .rd_data (line_rd)
   );

   sle_ram #(
      .WIDTH (8),
      .DEPTH (sle_pkg::BUF_DEPTH)
   ) u_send_store (
      .clock   (clock),
      .wr_en   (send_we),
      .wr_addr (send_wa),
      .wr_data (send_wd),
      .rd_addr (send_ra),
      .rd_data (send_rd)
   );

   sle_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (out_push),
      .ready        (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

/* sv/sle_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; holds the line store and the send store.
`default_nettype none

module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/sle_out_fifo.sv */
// Result queue of the serial line editor: takes up to three results a cycle while ready shows room.
// Depends on sle_pkg for the result types and queue sizes.
`default_nettype none

module sle_out_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sle_pkg::out_push_type push,
   output      logic                 ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [1:0]           rsp_kind,
   output      logic [7:0]           rsp_out_byte,
   output      logic                 rsp_last
);

   sle_pkg::res_type                      mem_ff [sle_pkg::OUT_DEPTH];
   logic [sle_pkg::OUT_PTR_W-1:0]         wp_ff, wp_in, rp_ff, rp_in;
   logic [sle_pkg::OUT_CNT_W-1:0]         count_ff, count_in;
   logic                                  pop;
   sle_pkg::res_type                      head;

   assign head         = mem_ff[rp_ff];
   assign rsp_valid    = (count_ff != '0);
   assign rsp_kind     = head.kind;
   assign rsp_out_byte = head.out_byte;
   assign rsp_last     = head.last;
   assign pop          = rsp_valid && !rsp_stall;
   assign ready        = (count_ff <= sle_pkg::OUT_CNT_W'(sle_pkg::OUT_DEPTH
                                                          - sle_pkg::MAX_RESULTS));

   always_comb begin
      wp_in    = wp_ff + sle_pkg::OUT_PTR_W'(push.count);
      rp_in    = pop ? rp_ff + sle_pkg::OUT_PTR_W'(1) : rp_ff;
      count_in = count_ff + sle_pkg::OUT_CNT_W'(push.count)
                 - (pop ? sle_pkg::OUT_CNT_W'(1) : sle_pkg::OUT_CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sle_pkg::MAX_RESULTS; i++) begin
         if (i < int'(push.count)) begin
            mem_ff[wp_ff + sle_pkg::OUT_PTR_W'(i)] <= push.item[i];
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sle_pkg::OUT_CNT_W'(sle_pkg::OUT_DEPTH))
      else $error("result queue count beyond its depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> ready)
      else $error("results pushed without room in the queue");

   a_empty_after_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == sle_pkg::OUT_CNT_W'(1) && pop && push.count == 2'd0)
      |=> !rsp_valid)
      else $error("queue not empty after its last beat left");

endmodule

`default_nettype wire

/* sv/sle_ctrl.sv */
// Sequencer of the serial line editor: edits lines, queues echoes and puts,
// serves readers and feeds the transmitter. Depends on sle_pkg.
`default_nettype none

module sle_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic [1:0]                  req_action,
   input  wire logic [7:0]                  req_data_byte,
   output      logic                        line_we,
   output      logic [sle_pkg::PTR_W-1:0]   line_wa,
   output      logic [7:0]                  line_wd,
   output      logic [sle_pkg::PTR_W-1:0]   line_ra,
   input  wire logic [7:0]                  line_rd,
   output      logic                        send_we,
   output      logic [sle_pkg::PTR_W-1:0]   send_wa,
   output      logic [7:0]                  send_wd,
   output      logic [sle_pkg::PTR_W-1:0]   send_ra,
   input  wire logic [7:0]                  send_rd,
   input  wire logic                        out_ready,
   output      sle_pkg::out_push_type       out_push
);

   localparam logic [sle_pkg::PTR_W-1:0] PTR_LAST = sle_pkg::PTR_W'(sle_pkg::BUF_DEPTH - 1);
   localparam logic [sle_pkg::CNT_W-1:0] CNT_FULL = sle_pkg::CNT_W'(sle_pkg::BUF_DEPTH);

   sle_pkg::state_type            state_ff, state_in;
   logic                          hold_valid_ff, hold_valid_in;
   logic [1:0]                    hold_action_ff, hold_action_in;
   logic [7:0]                    hold_byte_ff, hold_byte_in;
   logic [sle_pkg::PTR_W-1:0]     line_wp_ff, line_wp_in, line_rp_ff, line_rp_in;
   logic [sle_pkg::PTR_W-1:0]     send_wp_ff, send_wp_in, send_rp_ff, send_rp_in;
   logic [sle_pkg::CNT_W-1:0]     released_ff, released_in, editing_ff, editing_in;
   logic [sle_pkg::CNT_W-1:0]     send_cnt_ff, send_cnt_in;
   logic                          read_pending_ff, read_pending_in;
   logic                          sender_idle_ff, sender_idle_in;
   logic [1:0]                    push_cnt_ff, push_cnt_in, push_idx_ff, push_idx_in;
   logic [2:0][7:0]               push_bytes_ff, push_bytes_in;
   logic                          err_valid_ff, err_valid_in;
   sle_pkg::kind_type             err_kind_ff, err_kind_in;

   logic                          is_bs, is_eol, is_print, line_full, put_refuse;
   logic                          take, line_push_en;
   logic [1:0]                    idle_push_cnt;
   logic [2:0][7:0]               idle_push_bytes;
   logic                          idle_err;
   sle_pkg::kind_type             idle_err_kind;
   logic                          do_read, do_send, emit_go;
   logic [1:0]                    need;

   function automatic logic [sle_pkg::PTR_W-1:0] ptr_inc(input logic [sle_pkg::PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + sle_pkg::PTR_W'(1);
   endfunction

   function automatic logic [sle_pkg::PTR_W-1:0] ptr_dec(input logic [sle_pkg::PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - sle_pkg::PTR_W'(1);
   endfunction

   assign req_stall = hold_valid_ff;
   assign take      = (state_ff == sle_pkg::ST_IDLE) && hold_valid_ff;
   assign emit_go   = (state_ff == sle_pkg::ST_EMIT) && out_ready;
   assign do_read   = read_pending_ff && (released_ff != '0);
   assign do_send   = sender_idle_ff && (send_cnt_ff != '0);

   always_comb begin
      is_bs      = (hold_byte_ff == sle_pkg::CH_BS) || (hold_byte_ff == sle_pkg::CH_DEL);
      is_eol     = (hold_byte_ff == sle_pkg::CH_CR) || (hold_byte_ff == sle_pkg::CH_LF);
      is_print   = (hold_byte_ff >= sle_pkg::CH_PRINT_LO) && (hold_byte_ff < sle_pkg::CH_DEL);
      line_full  = ({1'b0, released_ff} + {1'b0, editing_ff}) >= {1'b0, CNT_FULL};
      need       = (hold_byte_ff == sle_pkg::CH_LF) ? 2'd2 : 2'd1;
      put_refuse = ({1'b0, send_cnt_ff} + (sle_pkg::CNT_W + 1)'(need)) > {1'b0, CNT_FULL};
      line_push_en = take && (hold_action_ff == sle_pkg::ACT_RX) && !is_bs
                     && (is_eol || is_print) && !line_full;
   end

   always_comb begin
      idle_push_cnt   = 2'd0;
      idle_push_bytes = '0;
      idle_err        = 1'b0;
      idle_err_kind   = sle_pkg::KIND_REFUSED;
      unique case (hold_action_ff)
         sle_pkg::ACT_RX: begin
            if (is_bs) begin
               if (editing_ff != '0) begin
                  idle_push_cnt   = 2'd3;
                  idle_push_bytes = {sle_pkg::CH_BS, sle_pkg::CH_SP, sle_pkg::CH_BS};
               end
            end else if (is_eol || is_print) begin
               if (!line_full) begin
                  idle_push_cnt      = is_eol ? 2'd2 : 2'd1;
                  idle_push_bytes[0] = is_eol ? sle_pkg::CH_CR : hold_byte_ff;
                  idle_push_bytes[1] = sle_pkg::CH_LF;
               end
            end
         end
         sle_pkg::ACT_READ: begin
            idle_err      = read_pending_ff;
            idle_err_kind = sle_pkg::KIND_SECOND_READER;
         end
         sle_pkg::ACT_PUT: begin
            if (put_refuse) begin
               idle_err = 1'b1;
            end else if (hold_byte_ff == sle_pkg::CH_LF) begin
               idle_push_cnt      = 2'd2;
               idle_push_bytes[0] = sle_pkg::CH_CR;
               idle_push_bytes[1] = sle_pkg::CH_LF;
            end else begin
               idle_push_cnt      = 2'd1;
               idle_push_bytes[0] = hold_byte_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sle_pkg::ST_IDLE: begin
            if (hold_valid_ff) begin
               state_in = (idle_push_cnt != 2'd0) ? sle_pkg::ST_PUSH : sle_pkg::ST_FETCH;
            end
         end
         sle_pkg::ST_PUSH: begin
            if (push_cnt_ff == 2'd1) begin
               state_in = sle_pkg::ST_FETCH;
            end
         end
         sle_pkg::ST_FETCH: begin
            state_in = sle_pkg::ST_EMIT;
         end
         sle_pkg::ST_EMIT: begin
            if (out_ready) begin
               state_in = sle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sle_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      line_we  = line_push_en;
      line_wa  = line_wp_ff;
      line_wd  = is_eol ? sle_pkg::CH_LF : hold_byte_ff;
      line_ra  = line_rp_ff;
      send_we  = (state_ff == sle_pkg::ST_PUSH) && (send_cnt_ff != CNT_FULL);
      send_wa  = send_wp_ff;
      send_wd  = push_bytes_ff[push_idx_ff];
      send_ra  = send_rp_ff;
      out_push = '0;
      if (emit_go) begin
         out_push.count = 2'({1'b0, err_valid_ff} + {1'b0, do_read} + {1'b0, do_send});
         if (err_valid_ff) begin
            out_push.item[0].kind = err_kind_ff;
            out_push.item[0].last = !do_read && !do_send;
         end
         if (do_read) begin
            out_push.item[{1'b0, err_valid_ff}].kind     = sle_pkg::KIND_READ;
            out_push.item[{1'b0, err_valid_ff}].out_byte = line_rd;
            out_push.item[{1'b0, err_valid_ff}].last     = !do_send;
         end
         if (do_send) begin
            out_push.item[2'({1'b0, err_valid_ff} + {1'b0, do_read})].kind = sle_pkg::KIND_TX;
            out_push.item[2'({1'b0, err_valid_ff} + {1'b0, do_read})].out_byte = send_rd;
            out_push.item[2'({1'b0, err_valid_ff} + {1'b0, do_read})].last = 1'b1;
         end
      end
   end

   always_comb begin
      hold_valid_in   = hold_valid_ff;
      hold_action_in  = hold_action_ff;
      hold_byte_in    = hold_byte_ff;
      line_wp_in      = line_wp_ff;
      line_rp_in      = line_rp_ff;
      send_wp_in      = send_wp_ff;
      send_rp_in      = send_rp_ff;
      released_in     = released_ff;
      editing_in      = editing_ff;
      send_cnt_in     = send_cnt_ff;
      read_pending_in = read_pending_ff;
      sender_idle_in  = sender_idle_ff;
      push_cnt_in     = push_cnt_ff;
      push_idx_in     = push_idx_ff;
      push_bytes_in   = push_bytes_ff;
      err_valid_in    = err_valid_ff;
      err_kind_in     = err_kind_ff;
      unique case (state_ff)
         sle_pkg::ST_IDLE: begin
            if (hold_valid_ff) begin
               hold_valid_in = 1'b0;
               push_cnt_in   = idle_push_cnt;
               push_idx_in   = 2'd0;
               push_bytes_in = idle_push_bytes;
               err_valid_in  = idle_err;
               err_kind_in   = idle_err_kind;
               unique case (hold_action_ff)
                  sle_pkg::ACT_RX: begin
                     if (is_bs) begin
                        if (editing_ff != '0) begin
                           editing_in = editing_ff - sle_pkg::CNT_W'(1);
                           line_wp_in = ptr_dec(line_wp_ff);
                        end
                     end else if (line_push_en) begin
                        line_wp_in = ptr_inc(line_wp_ff);
                        if (is_eol) begin
                           released_in = released_ff + editing_ff + sle_pkg::CNT_W'(1);
                           editing_in  = '0;
                        end else begin
                           editing_in = editing_ff + sle_pkg::CNT_W'(1);
                        end
                     end
                  end
                  sle_pkg::ACT_READ: begin
                     read_pending_in = 1'b1;
                  end
                  sle_pkg::ACT_PUT: begin
                  end
                  default: begin
                     sender_idle_in = 1'b1;
                  end
               endcase
            end
         end
         sle_pkg::ST_PUSH: begin
            if (send_cnt_ff != CNT_FULL) begin
               send_wp_in  = ptr_inc(send_wp_ff);
               send_cnt_in = send_cnt_ff + sle_pkg::CNT_W'(1);
            end
            push_idx_in = push_idx_ff + 2'd1;
            push_cnt_in = push_cnt_ff - 2'd1;
         end
         sle_pkg::ST_FETCH: begin
         end
         sle_pkg::ST_EMIT: begin
            if (out_ready) begin
               err_valid_in = 1'b0;
               if (do_read) begin
                  line_rp_in      = ptr_inc(line_rp_ff);
                  released_in     = released_ff - sle_pkg::CNT_W'(1);
                  read_pending_in = 1'b0;
               end
               if (do_send) begin
                  send_rp_in     = ptr_inc(send_rp_ff);
                  send_cnt_in    = send_cnt_ff - sle_pkg::CNT_W'(1);
                  sender_idle_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      if (req_valid && !req_stall) begin
         hold_valid_in  = 1'b1;
         hold_action_in = req_action;
         hold_byte_in   = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= sle_pkg::ST_IDLE;
         hold_valid_ff   <= 1'b0;
         line_wp_ff      <= '0;
         line_rp_ff      <= '0;
         send_wp_ff      <= '0;
         send_rp_ff      <= '0;
         released_ff     <= '0;
         editing_ff      <= '0;
         send_cnt_ff     <= '0;
         read_pending_ff <= 1'b0;
         sender_idle_ff  <= 1'b1;
         push_cnt_ff     <= '0;
         push_idx_ff     <= '0;
         err_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         hold_valid_ff   <= hold_valid_in;
         line_wp_ff      <= line_wp_in;
         line_rp_ff      <= line_rp_in;
         send_wp_ff      <= send_wp_in;
         send_rp_ff      <= send_rp_in;
         released_ff     <= released_in;
         editing_ff      <= editing_in;
         send_cnt_ff     <= send_cnt_in;
         read_pending_ff <= read_pending_in;
         sender_idle_ff  <= sender_idle_in;
         push_cnt_ff     <= push_cnt_in;
         push_idx_ff     <= push_idx_in;
         err_valid_ff    <= err_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_action_ff <= hold_action_in;
      hold_byte_ff   <= hold_byte_in;
      push_bytes_ff  <= push_bytes_in;
      err_kind_ff    <= err_kind_in;
   end

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, released_ff} + {1'b0, editing_ff}) <= {1'b0, CNT_FULL})
      else $error("line store holds more characters than its depth");

   a_send_bound: assert property (@(posedge clock) disable iff (reset)
      send_cnt_ff <= CNT_FULL)
      else $error("send queue count beyond its depth");

   a_push_in_emit: assert property (@(posedge clock) disable iff (reset)
      (out_push.count != 2'd0) |-> (state_ff == sle_pkg::ST_EMIT))
      else $error("results pushed outside the emit step");

   a_take_frees_hold: assert property (@(posedge clock) disable iff (reset)
      take |=> (!hold_valid_ff && state_ff != sle_pkg::ST_IDLE))
      else $error("held beat not released when its work started");

   a_no_write_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sle_pkg::ST_EMIT || state_ff == sle_pkg::ST_FETCH)
      |-> (!line_we && !send_we))
      else $error("store written while its read data is in use");

endmodule

`default_nettype wire

/* bench/serial_line_editor_with_echo_test.sv */
// Self-checking bench for the serial line editor: it drives character, read, put and
// done beats, predicts every result beat and compares them in order.
// Depends on sle_pkg and serial_line_editor_with_echo.
module serial_line_editor_with_echo_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sle_pkg::*;

   localparam int STUCK_LIMIT = 2000;

   typedef struct {
      action_type act;
      logic [7:0] data;
   } req_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = ACT_RX;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   req_beat_type input_beats[$];
   res_type      awaited_results[$];

   // Mirror of the line discipline state.
   logic [7:0] line_mem [BUF_DEPTH];
   logic [7:0] echo_mem [BUF_DEPTH];
   int  line_head = 0;
   int  line_tail = 0;
   int  ready_chars = 0;
   int  typed_chars = 0;
   int  tx_head = 0;
   int  tx_tail = 0;
   int  tx_count = 0;
   bit  reader_waiting = 1'b0;
   bit  tx_free = 1'b1;

   int  mismatches = 0;
   int  beats_in = 0;
   int  beats_out = 0;
   int  kind_count [4] = '{0, 0, 0, 0};
   int  queued_beats = 0;
   int  req_gap = 0;
   int  rsp_hold = 0;
   int  stuck = 0;
   bit  req_burst = 1'b0;
   bit  rsp_burst = 1'b0;

   serial_line_editor_with_echo dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int wrap_up(int p);
      return (p + 1 >= BUF_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic int next_pause(inout bit burst);
      if ($urandom_range(0, 19) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [7:0] any_printable();
      return 8'($urandom_range(CH_PRINT_LO, CH_DEL - 1));
   endfunction

   function automatic res_type make_result(kind_type k, logic [7:0] b);
      res_type r;
      r.kind = k;
      r.out_byte = b;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic queue_echo(logic [7:0] c);
      if (tx_count < BUF_DEPTH) begin
         echo_mem[tx_head] = c;
         tx_head = wrap_up(tx_head);
         tx_count++;
      end
   endtask

   task automatic store_char(logic [7:0] c);
      line_mem[line_head] = c;
      line_head = wrap_up(line_head);
      typed_chars++;
   endtask

   task automatic apply_discipline(action_type act, logic [7:0] c);
      res_type outs[$];
      int need;
      case (act)
         ACT_RX: begin
            if (c == CH_BS || c == CH_DEL) begin
               if (typed_chars > 0) begin
                  typed_chars--;
                  line_head = (line_head == 0) ? BUF_DEPTH - 1 : line_head - 1;
                  queue_echo(CH_BS);
                  queue_echo(CH_SP);
                  queue_echo(CH_BS);
               end
            end else if (c == CH_CR || c == CH_LF) begin
               if (ready_chars + typed_chars < BUF_DEPTH) begin
                  store_char(CH_LF);
                  ready_chars += typed_chars;
                  typed_chars = 0;
                  queue_echo(CH_CR);
                  queue_echo(CH_LF);
               end
            end else if (c >= CH_PRINT_LO && c < CH_DEL) begin
               if (ready_chars + typed_chars < BUF_DEPTH) begin
                  store_char(c);
                  queue_echo(c);
               end
            end
         end
         ACT_READ: begin
            if (reader_waiting) outs.push_back(make_result(KIND_SECOND_READER, 8'h00));
            reader_waiting = 1'b1;
         end
         ACT_PUT: begin
            need = (c == CH_LF) ? 2 : 1;
            if (tx_count + need > BUF_DEPTH) begin
               outs.push_back(make_result(KIND_REFUSED, 8'h00));
            end else begin
               if (c == CH_LF) queue_echo(CH_CR);
               queue_echo(c);
            end
         end
         default: tx_free = 1'b1;
      endcase
      if (reader_waiting && ready_chars > 0) begin
         outs.push_back(make_result(KIND_READ, line_mem[line_tail]));
         line_tail = wrap_up(line_tail);
         ready_chars--;
         reader_waiting = 1'b0;
      end
      if (tx_free && tx_count > 0) begin
         outs.push_back(make_result(KIND_TX, echo_mem[tx_tail]));
         tx_tail = wrap_up(tx_tail);
         tx_count--;
         tx_free = 1'b0;
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) awaited_results.push_back(outs[i]);
   endtask

   task automatic flag_error(string why);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $time, why);
   endtask

   task automatic push_beat(action_type act, logic [7:0] data);
      req_beat_type b;
      b.act = act;
      b.data = data;
      input_beats.push_back(b);
      queued_beats++;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (input_beats.size() != 0 || req_valid || awaited_results.size() != 0);
   endtask

   always @(posedge clock) begin : drive_requests
      req_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_action <= ACT_RX;
         req_data_byte <= 8'h00;
         req_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) req_gap = next_pause(req_burst);
         if (req_gap == 0 && input_beats.size() > 0) begin
            nxt = input_beats.pop_front();
            req_valid <= 1'b1;
            req_action <= nxt.act;
            req_data_byte <= nxt.data;
         end else begin
            if (req_gap > 0) req_gap--;
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_hold = next_pause(rsp_burst);
         else if (rsp_hold > 0) rsp_hold--;
         rsp_stall <= (rsp_hold > 0);
      end
   end

   always @(posedge clock) begin : watch_beats
      res_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_discipline(action_type'(req_action), req_data_byte);
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (awaited_results.size() == 0) begin
               flag_error($sformatf("unexpected result: kind %0d byte %02h last %0b",
                                    rsp_kind, rsp_out_byte, rsp_last));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_kind !== want.kind || rsp_out_byte !== want.out_byte ||
                   rsp_last !== want.last) begin
                  flag_error($sformatf(
                     "result %0d: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                     beats_out, want.kind, want.out_byte, want.last,
                     rsp_kind, rsp_out_byte, rsp_last));
               end
               kind_count[want.kind]++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck = 0;
      end else begin
         stuck++;
         if (stuck >= STUCK_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles.", STUCK_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int made;
      int mark;
      bit noise;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_beat(ACT_READ, 8'h00);
      push_beat(ACT_READ, 8'hFF);
      push_beat(ACT_RX, CH_BS);
      push_beat(ACT_RX, 8'h00);
      push_beat(ACT_RX, 8'hFF);
      push_beat(ACT_RX, 8'h1F);
      push_beat(ACT_RX, CH_SP);
      push_beat(ACT_RX, CH_DEL - 1);
      push_beat(ACT_RX, CH_DEL);
      push_beat(ACT_DONE, 8'h00);
      push_beat(ACT_RX, 8'h41);
      push_beat(ACT_RX, CH_CR);
      push_beat(ACT_READ, 8'h00);
      push_beat(ACT_RX, CH_LF);
      push_beat(ACT_PUT, CH_LF);
      push_beat(ACT_PUT, 8'h00);
      push_beat(ACT_PUT, 8'hFF);
      repeat (8) push_beat(ACT_DONE, 8'hFF);
      settle();

      made = 0;
      while (made < 100) begin
         mark = queued_beats;
         noise = 1'b0;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               repeat ($urandom_range(1, 6)) push_beat(ACT_RX, any_printable());
               if ($urandom_range(0, 2) == 0)
                  push_beat(ACT_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL);
               if ($urandom_range(0, 4) != 0)
                  push_beat(ACT_RX, $urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            4, 5: repeat ($urandom_range(1, 3)) push_beat(ACT_READ, 8'($urandom_range(0, 255)));
            6, 7: repeat ($urandom_range(2, 8)) push_beat(ACT_DONE, 8'($urandom_range(0, 255)));
            8: push_beat(ACT_PUT, ($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
            default: begin
               push_beat(action_type'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
               noise = 1'b1;
            end
         endcase
         if (!noise) made += queued_beats - mark;
      end
      settle();

      // Empty the released text, then fill the line store and the send queue.
      repeat (ready_chars) push_beat(ACT_READ, 8'h00);
      repeat (BUF_DEPTH - typed_chars + 4) push_beat(ACT_RX, any_printable());
      settle();
      repeat (BUF_DEPTH - tx_count + 2) push_beat(ACT_PUT, any_printable());
      push_beat(ACT_PUT, CH_LF);
      push_beat(ACT_DONE, 8'h00);
      push_beat(ACT_PUT, CH_LF);
      push_beat(ACT_PUT, any_printable());
      push_beat(ACT_RX, any_printable());
      push_beat(ACT_RX, CH_CR);
      push_beat(ACT_RX, CH_BS);
      push_beat(ACT_RX, CH_DEL);
      push_beat(ACT_RX, CH_CR);
      repeat (2) push_beat(ACT_READ, 8'h00);
      repeat (4) push_beat(ACT_DONE, 8'h00);
      settle();
      repeat (20) @(posedge clock);

      $display("Covered %0d request beats and %0d result beats: %0d characters read, %0d sent,",
               beats_in, beats_out, kind_count[KIND_READ], kind_count[KIND_TX]);
      $display("%0d puts refused and %0d second-reader flags, with both stores run full.",
               kind_count[KIND_REFUSED], kind_count[KIND_SECOND_READER]);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d result errors.", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
